### rtl/mtt3_pkg.sv
// mtt3_pkg: widths, stage payload types and the per-stage square root and
// divider step functions of the move-toward-target pipeline
// no dependencies
`default_nettype none

package mtt3_pkg;

  localparam int PosW   = 32;
  localparam int MagW   = 33;
  localparam int SpdW   = 31;
  localparam int TsW    = 20;
  localparam int TspW   = SpdW + TsW;
  localparam int StepW  = 31;
  localparam int Step2W = 2 * StepW;
  localparam int SqW    = 66;
  localparam int NumW   = 64;
  localparam int RootW  = 33;
  localparam int SrmW   = 34;
  localparam int QuoW   = 33;
  localparam int DremW  = 33;
  localparam int DataInW  = 224;
  localparam int DataOutW = 96;

  localparam logic [TsW-1:0] TsReset = 20'd1092;

  // apb register word indexes
  localparam logic RegTimeStep = 1'b0;

  typedef struct packed {
    logic [2:0][PosW-1:0] pos;
    logic [2:0][PosW-1:0] goal;
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic [SpdW-1:0]      speed;
    logic                 moving;
  } st1_t;

  typedef struct packed {
    logic [2:0][PosW-1:0] pos;
    logic [2:0][PosW-1:0] goal;
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic [2:0][SqW-1:0]  sq;
    logic [TspW-1:0]      tsp;
    logic                 moving;
  } st2_t;

  typedef struct packed {
    logic [2:0][PosW-1:0] pos;
    logic [2:0][PosW-1:0] goal;
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
    logic [SqW-1:0]       dsq;
    logic [StepW-1:0]     step;
    logic                 moving;
  } st3_t;

  typedef struct packed {
    logic [2:0][PosW-1:0] pos;
    logic [2:0][PosW-1:0] goal;
    logic [2:0]           neg;
    logic [SqW-1:0]       dsq;
    logic [Step2W-1:0]    step2;
    logic [2:0][NumW-1:0] num;
    logic                 moving;
  } st4_t;

  typedef struct packed {
    logic [2:0][PosW-1:0] base;
    logic [2:0]           neg;
    logic                 go;
    logic                 arr;
  } ctl_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic [2:0][NumW-1:0] num;
    logic [SqW-1:0]       rad;
    logic [SrmW-1:0]      rem;
    logic [RootW-1:0]     root;
  } sqs_t;

  typedef struct packed {
    ctl_t                  ctl;
    logic [RootW-1:0]      dvsr;
    logic [2:0][QuoW-1:0]  nbits;
    logic [2:0][DremW-1:0] rem;
    logic [2:0][QuoW-1:0]  quo;
  } dvs_t;

  // one result bit of the restoring square root
  function automatic sqs_t sqrt_step(sqs_t s);
    sqs_t            r;
    logic [SrmW+1:0] r2;
    logic [SrmW+1:0] trial;
    r     = s;
    r2    = {s.rem, s.rad[SqW-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[SqW-3:0], 2'b00};
    if (r2 >= trial) begin
      r.rem  = SrmW'(r2 - trial);
      r.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = SrmW'(r2);
      r.root = {s.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of the restoring divider, all three axes
  function automatic dvs_t div_step(dvs_t s);
    dvs_t           r;
    logic [DremW:0] r2;
    r = s;
    for (int i = 0; i < 3; i++) begin
      r2 = {s.rem[i], s.nbits[i][QuoW-1]};
      r.nbits[i] = {s.nbits[i][QuoW-2:0], 1'b0};
      if (r2 >= {1'b0, s.dvsr}) begin
        r.rem[i] = DremW'(r2 - {1'b0, s.dvsr});
        r.quo[i] = {s.quo[i][QuoW-2:0], 1'b1};
      end else begin
        r.rem[i] = DremW'(r2);
        r.quo[i] = {s.quo[i][QuoW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/move_toward_target_3d_top.sv
// move_toward_target_3d_top: steps one entity position toward its goal per transfer
// through a fully pipelined distance, square root and divider datapath
// depends on mtt3_pkg
//
// usage
//   s_axis carries one entity per transfer: position, goal and speed limit in
//   tdata, the active flag in tuser. m_axis returns the updated position in
//   tdata and still_moving / arrived in tuser, one result per transfer, in order.
//   time_step is an apb register at byte address 0, written while idle.
// pipeline and throughput
//   73 register stages: difference, squares, sum and step, products, compare,
//   33 square root stages, divider entry, 33 divider stages and the output
//   register. one transfer per cycle is sustained while the output is not held.
// reset
//   clears all stage valid bits and loads time_step with 1092 (about 1/60 s).
// stall
//   while the output is held the whole pipeline freezes; the first stage still
//   takes a transfer when it is empty, so nothing is lost or repeated.
`default_nettype none

module move_toward_target_3d_top
  import mtt3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // pos_x, pos_y, pos_z, goal_x, goal_y, goal_z, speed_limit, zero pad
  input  wire logic [DataInW-1:0]  s_axis_tdata,
  // moving
  input  wire logic [0:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // new_x, new_y, new_z
  output logic [DataOutW-1:0]      m_axis_tdata,
  // still_moving, arrived
  output logic [1:0]               m_axis_tuser,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int SqBase = 4;
  localparam int DvBase = SqBase + RootW + 1;
  localparam int Last   = DvBase + QuoW + 1;
  localparam int NStg   = Last + 1;

  logic [TsW-1:0]  ts_q;
  logic [NStg-1:0] vld_q;
  logic            en;
  logic            load1;

  st1_t st1_q, st1_d;
  st2_t st2_q, st2_d;
  st3_t st3_q, st3_d;
  st4_t st4_q, st4_d;
  sqs_t sqr_q [RootW+1];
  sqs_t sqr_d;
  dvs_t dv_q [QuoW+1];
  dvs_t dv_d;
  logic [DataOutW-1:0] out_data_q, out_data_d;
  logic [1:0]          out_user_q, out_user_d;

  // apb register
  assign pready = 1'b1;
  assign prdata = {{(32-TsW){1'b0}}, ts_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TsReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegTimeStep)) begin
      ts_q <= pwdata[TsW-1:0];
    end
  end

  // flow control
  assign en            = !vld_q[Last] || m_axis_tready;
  assign load1         = en || !vld_q[0];
  assign s_axis_tready = load1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (load1) begin
        vld_q[0] <= s_axis_tvalid;
      end
      if (en) begin
        vld_q[NStg-1:1] <= vld_q[NStg-2:0];
      end
    end
  end

  // stage 1: differences and magnitudes
  always_comb begin
    logic signed [PosW:0] d;
    st1_d = '0;
    for (int i = 0; i < 3; i++) begin
      st1_d.pos[i]  = s_axis_tdata[i*PosW +: PosW];
      st1_d.goal[i] = s_axis_tdata[(i+3)*PosW +: PosW];
      d = $signed({st1_d.goal[i][PosW-1], st1_d.goal[i]})
        - $signed({st1_d.pos[i][PosW-1], st1_d.pos[i]});
      st1_d.neg[i] = d[PosW];
      st1_d.mag[i] = d[PosW] ? MagW'(-d) : MagW'(d);
    end
    st1_d.speed  = s_axis_tdata[6*PosW +: SpdW];
    st1_d.moving = s_axis_tuser[0];
  end

  // stage 2: squares and raw step product
  always_comb begin
    st2_d.pos    = st1_q.pos;
    st2_d.goal   = st1_q.goal;
    st2_d.mag    = st1_q.mag;
    st2_d.neg    = st1_q.neg;
    st2_d.moving = st1_q.moving;
    for (int i = 0; i < 3; i++) begin
      st2_d.sq[i] = SqW'(st1_q.mag[i]) * SqW'(st1_q.mag[i]);
    end
    st2_d.tsp = TspW'(st1_q.speed) * TspW'(ts_q);
  end

  // stage 3: squared distance and saturated step
  always_comb begin
    logic [TspW-1:0] sh;
    sh           = st2_q.tsp >> FRAC_BITS;
    st3_d.pos    = st2_q.pos;
    st3_d.goal   = st2_q.goal;
    st3_d.mag    = st2_q.mag;
    st3_d.neg    = st2_q.neg;
    st3_d.moving = st2_q.moving;
    st3_d.dsq    = st2_q.sq[0] + st2_q.sq[1] + st2_q.sq[2];
    st3_d.step   = (|sh[TspW-1:StepW]) ? '1 : sh[StepW-1:0];
  end

  // stage 4: step squared and per-axis dividends
  always_comb begin
    st4_d.pos    = st3_q.pos;
    st4_d.goal   = st3_q.goal;
    st4_d.neg    = st3_q.neg;
    st4_d.moving = st3_q.moving;
    st4_d.dsq    = st3_q.dsq;
    st4_d.step2  = Step2W'(st3_q.step) * Step2W'(st3_q.step);
    for (int i = 0; i < 3; i++) begin
      st4_d.num[i] = NumW'(st3_q.mag[i]) * NumW'(st3_q.step);
    end
  end

  // stage 5: arrival decision, square root entry
  always_comb begin
    logic arr;
    arr           = st4_q.moving && (st4_q.dsq <= SqW'(st4_q.step2));
    sqr_d.ctl.base = arr ? st4_q.goal : st4_q.pos;
    sqr_d.ctl.neg  = st4_q.neg;
    sqr_d.ctl.go   = st4_q.moving && !arr;
    sqr_d.ctl.arr  = arr;
    sqr_d.num      = st4_q.num;
    sqr_d.rad      = st4_q.dsq;
    sqr_d.rem      = '0;
    sqr_d.root     = '0;
  end

  // divider entry
  always_comb begin
    dv_d.ctl  = sqr_q[RootW].ctl;
    dv_d.dvsr = sqr_q[RootW].root;
    dv_d.quo  = '0;
    for (int i = 0; i < 3; i++) begin
      dv_d.rem[i]   = DremW'(sqr_q[RootW].num[i][NumW-1:QuoW]);
      dv_d.nbits[i] = sqr_q[RootW].num[i][QuoW-1:0];
    end
  end

  // output
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_q[QuoW].ctl.go) begin
        out_data_d[i*PosW +: PosW] = dv_q[QuoW].ctl.base[i];
      end else if (dv_q[QuoW].ctl.neg[i]) begin
        out_data_d[i*PosW +: PosW] = dv_q[QuoW].ctl.base[i] - dv_q[QuoW].quo[i][PosW-1:0];
      end else begin
        out_data_d[i*PosW +: PosW] = dv_q[QuoW].ctl.base[i] + dv_q[QuoW].quo[i][PosW-1:0];
      end
    end
    out_user_d = {dv_q[QuoW].ctl.arr, dv_q[QuoW].ctl.go};
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      st1_q <= st1_d;
    end
    if (en) begin
      st2_q    <= st2_d;
      st3_q    <= st3_d;
      st4_q    <= st4_d;
      sqr_q[0] <= sqr_d;
      for (int k = 0; k < RootW; k++) begin
        sqr_q[k+1] <= sqrt_step(sqr_q[k]);
      end
      dv_q[0] <= dv_d;
      for (int k = 0; k < QuoW; k++) begin
        dv_q[k+1] <= div_step(dv_q[k]);
      end
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = vld_q[Last];
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("still_moving and arrived both set");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (vld_q[0] && vld_q[Last] && !m_axis_tready))
    else $error("input blocked without an output stall");

  a_ts_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[2] == RegTimeStep)) |=>
      (ts_q == $past(pwdata[TsW-1:0])))
    else $error("time_step write lost");

  a_stall_holds_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && vld_q[0]) |=> vld_q[0])
    else $error("stalled item dropped from first stage");

endmodule

`default_nettype wire

### bench/move_toward_target_3d_checker.sv
// move_toward_target_3d_checker: watches both stream channels and the apb port,
// predicts each updated position and compares it with the returned transfer
// depends on mtt3_pkg
`timescale 1ns / 100ps
`default_nettype none

module move_toward_target_3d_checker
  import mtt3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [DataInW-1:0]  s_axis_tdata,
  input  wire logic [0:0]          s_axis_tuser,
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [DataOutW-1:0] m_axis_tdata,
  input  wire logic [1:0]          m_axis_tuser,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  input  wire logic                pready,
  output int                       fail_count,
  output int                       pending,
  output int                       arrivals,
  output int                       partials
);

  typedef struct packed {
    logic [2:0][PosW-1:0] pos;
    logic                 still;
    logic                 arr;
  } motion_t;

  motion_t         motion_mem [1024];
  int              wr_cnt;
  int              rd_cnt;
  logic [TsW-1:0]  ts_shadow;

  function automatic logic [127:0] isqrt(logic [127:0] v);
    logic [127:0] r;
    logic [127:0] c;
    r = 0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic motion_t advance(logic [DataInW-1:0] d, logic act, logic [TsW-1:0] ts);
    motion_t        m;
    logic signed [63:0] p[3];
    logic signed [63:0] g[3];
    logic signed [63:0] df[3];
    logic [127:0]   mg[3];
    logic [127:0]   sq;
    logic [127:0]   stp;
    logic [127:0]   dlen;
    logic [127:0]   q;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      p[i]  = 64'(signed'(d[32*i +: 32]));
      g[i]  = 64'(signed'(d[32*(i+3) +: 32]));
      df[i] = g[i] - p[i];
      mg[i] = df[i] < 0 ? 128'(-df[i]) : 128'(df[i]);
      sq    = sq + mg[i] * mg[i];
    end
    stp = (128'(d[192 +: 31]) * 128'(ts)) >> FRAC_BITS;
    if (stp > 128'd2147483647) stp = 128'd2147483647;
    if (!act) begin
      for (int i = 0; i < 3; i++) m.pos[i] = p[i][31:0];
      m.still = 1'b0;
      m.arr   = 1'b0;
    end else if (sq <= stp * stp) begin
      for (int i = 0; i < 3; i++) m.pos[i] = g[i][31:0];
      m.still = 1'b0;
      m.arr   = 1'b1;
    end else begin
      dlen = isqrt(sq);
      if (dlen == 0) dlen = 1;
      for (int i = 0; i < 3; i++) begin
        q = (mg[i] * stp) / dlen;
        m.pos[i] = df[i] < 0 ? 32'(p[i] - 64'(q)) : 32'(p[i] + 64'(q));
      end
      m.still = 1'b1;
      m.arr   = 1'b0;
    end
    return m;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    motion_t exp_m;
    if (!rst_ni) begin
      ts_shadow  <= TsReset;
      fail_count <= 0;
      arrivals   <= 0;
      partials   <= 0;
      wr_cnt     <= 0;
      rd_cnt     <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == RegTimeStep)
        ts_shadow <= pwdata[TsW-1:0];
      if (s_axis_tvalid && s_axis_tready) begin
        motion_mem[wr_cnt[9:0]] <= advance(s_axis_tdata, s_axis_tuser[0], ts_shadow);
        wr_cnt <= wr_cnt + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (wr_cnt == rd_cnt) begin
          if (fail_count < 10) $display("unexpected result transfer %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_m = motion_mem[rd_cnt[9:0]];
          rd_cnt <= rd_cnt + 1;
          if (exp_m.arr) arrivals <= arrivals + 1;
          if (exp_m.still) partials <= partials + 1;
          if (m_axis_tdata != exp_m.pos || m_axis_tuser != {exp_m.arr, exp_m.still}) begin
            if (fail_count < 10)
              $display("mismatch: exp pos %h still %b arr %b, got pos %h tuser %b",
                       exp_m.pos, exp_m.still, exp_m.arr, m_axis_tdata, m_axis_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = wr_cnt - rd_cnt;

endmodule

`default_nettype wire

### bench/move_toward_target_3d_top_tb.sv
// move_toward_target_3d_top_tb: drives entities and time step settings into the
// block with random gaps and stalls, verdict from the checker's failure count
// depends on mtt3_pkg, move_toward_target_3d_top, move_toward_target_3d_checker
`timescale 1ns / 100ps
`default_nettype none

module move_toward_target_3d_top_tb;
  import mtt3_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataInW-1:0]  s_axis_tdata = '0;
  logic [0:0]          s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DataOutW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count;
  int                  pending;
  int                  arrivals;
  int                  partials;
  int                  idle_cycles = 0;
  int                  sent = 0;

  localparam int IdleLimit = 20000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  move_toward_target_3d_top u_dut (.*);

  move_toward_target_3d_checker u_chk (.*);

  task automatic write_time_step(logic [TsW-1:0] ts);
    @(negedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {RegTimeStep, 2'b00};
    pwdata <= 32'(ts);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic send_entity(logic [2:0][31:0] p, logic [2:0][31:0] g,
                             logic [30:0] spd, logic act);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk_i);
    s_axis_tdata  <= {1'b0, spd, g, p};
    s_axis_tuser  <= act;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    sent++;
  endtask

  function automatic logic [31:0] near(logic [31:0] b, int span);
    return b + 32'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic random_entity();
    logic [2:0][31:0] p;
    logic [2:0][31:0] g;
    logic [30:0]      spd;
    int               kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      p[i] = $urandom();
      g[i] = kind < 4 ? near(p[i], 1 << $urandom_range(0, 20)) : $urandom();
    end
    spd = kind == 9 ? 31'($urandom()) : 31'($urandom_range(0, 1 << $urandom_range(0, 30)));
    send_entity(p, g, spd, $urandom_range(0, 7) != 0);
  endtask

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, 8);
      if (sent > 300 && sent < 340) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    logic [2:0][31:0] z;
    logic [2:0][31:0] mx;
    logic [2:0][31:0] mn;
    logic [TsW-1:0]   ts_set[5];
    z  = '0;
    mx = {3{32'h7fffffff}};
    mn = {3{32'h80000000}};
    ts_set = '{20'hfffff, 20'd0, 20'd1, 20'd65536, 20'($urandom())};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    // reset time step
    send_entity(z, z, 31'h7fffffff, 1'b1);
    send_entity(mn, mx, 31'h7fffffff, 1'b1);
    send_entity(mx, mn, 31'd65536, 1'b1);
    send_entity(mx, mn, 31'd0, 1'b1);
    send_entity(mn, mx, 31'd12345, 1'b0);
    send_entity(z, {32'd0, 32'd0, 32'd1093}, 31'd65536, 1'b1);
    send_entity(z, {32'd0, 32'd0, 32'hffffffff}, 31'd0, 1'b1);
    send_entity(z, {32'd300, 32'd400, 32'd0}, 31'd196608, 1'b1);
    drain();
    for (int k = 0; k < 5; k++) begin
      write_time_step(ts_set[k]);
      send_entity(mn, mx, 31'h7fffffff, 1'b1);
      send_entity(z, {32'd0, 32'd0, 32'd1}, 31'd1, 1'b1);
      for (int n = 0; n < 95; n++) random_entity();
      drain();
    end
    $display("covered %0d entities over 6 time step settings: %0d arrivals, %0d partial moves",
             sent, arrivals, partials);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
